/* sv/lpu_pkg.sv */
// shared types, constants and fixed-point helpers for the lens point undistort block
`default_nettype none
package lpu_pkg;

  localparam int FracBits = 28;
  localparam logic signed [63:0] QOne = 64'sd268435456;
  localparam logic signed [63:0] QHalf = 64'sd134217728;
  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  localparam int RegAddrW = 5;
  localparam logic [2:0] REG_K_RADIAL_1 = 3'd0;
  localparam logic [2:0] REG_K_RADIAL_2 = 3'd1;
  localparam logic [2:0] REG_P_TANGENTIAL_1 = 3'd2;
  localparam logic [2:0] REG_P_TANGENTIAL_2 = 3'd3;
  localparam logic [2:0] REG_INV_SCALE_X = 3'd4;
  localparam logic [2:0] REG_INV_SCALE_Y = 3'd5;
  localparam logic [2:0] REG_OFFSET_X = 3'd6;
  localparam logic [2:0] REG_OFFSET_Y = 3'd7;

  typedef struct packed {
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
  } pix_t;

  typedef struct packed {
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               denom_bad;
  } res_t;

  typedef struct packed {
    logic signed [31:0] k_radial_1;
    logic signed [31:0] k_radial_2;
    logic signed [31:0] p_tangential_1;
    logic signed [31:0] p_tangential_2;
    logic [30:0]        inv_scale_x;
    logic [30:0]        inv_scale_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } cfg_t;

  // lane side channel through the divider
  typedef struct packed {
    logic               vld;
    logic               bad;
    logic signed [31:0] coord;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7fffffff;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half up, drop the fraction of a q4.28 product, then saturate
  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + QHalf) >>> FracBits;
    return sat32(t);
  endfunction

endpackage
`default_nettype wire

/* sv/lpu_front.sv */
// pipeline from pixel to normalized point, residual and correction denominator
`default_nettype none
module lpu_front
  import lpu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire pix_t               pix_i,
  input  wire cfg_t               cfg_i,
  output logic                    vld_o,
  output logic signed [31:0]      x_o,
  output logic signed [31:0]      y_o,
  output logic signed [31:0]      res_x_o,
  output logic signed [31:0]      res_y_o,
  output logic signed [31:0]      den_o
);

  localparam int Depth = 12;

  logic [Depth-1:0] vld_q;

  logic [46:0] s1_mu_q, s1_mv_q;
  logic signed [31:0] s2_x_q, s2_y_q;
  logic signed [63:0] s3_mxx_q, s3_myy_q, s3_mxy_q, s3_mp1y_q, s3_mp2x_q;
  logic signed [31:0] s3_x_q, s3_y_q;
  logic signed [31:0] s4_xx_q, s4_yy_q, s4_xy_q, s4_p1y_q, s4_p2x_q, s4_x_q, s4_y_q;
  logic signed [31:0] s5_r2_q, s5_xx_q, s5_yy_q, s5_xy_q, s5_p1y_q, s5_p2x_q, s5_x_q, s5_y_q;
  logic signed [63:0] s6_mr4_q, s6_mk1r2_q, s6_mp1xy_q, s6_mp2xy_q;
  logic signed [31:0] s6_sx_q, s6_sy_q, s6_p1y_q, s6_p2x_q, s6_x_q, s6_y_q;
  logic signed [31:0] s7_r4_q, s7_k1r2_q, s7_p1xy_q, s7_p2xy_q;
  logic signed [63:0] s7_mp2sx_q, s7_mp1sy_q;
  logic signed [31:0] s7_p1y_q, s7_p2x_q, s7_x_q, s7_y_q;
  logic signed [63:0] s8_mk2r4_q;
  logic signed [31:0] s8_k1r2_q, s8_p1xy_q, s8_p2xy_q, s8_p2sx_q, s8_p1sy_q;
  logic signed [31:0] s8_p1y_q, s8_p2x_q, s8_x_q, s8_y_q;
  logic signed [31:0] s9_k2r4_q, s9_k1r2_q, s9_tx_q, s9_ty_q;
  logic signed [31:0] s9_p1y_q, s9_p2x_q, s9_x_q, s9_y_q;
  logic signed [31:0] s10_rad_q, s10_den_q, s10_tx_q, s10_ty_q, s10_x_q, s10_y_q;
  logic signed [63:0] s11_mrx_q, s11_mry_q;
  logic signed [31:0] s11_den_q, s11_tx_q, s11_ty_q, s11_x_q, s11_y_q;
  logic signed [31:0] s12_rx_q, s12_ry_q, s12_den_q, s12_x_q, s12_y_q;

  logic [46:0] rnd_u, rnd_v;
  logic signed [63:0] den_sum;

  assign rnd_u = s1_mu_q + 47'd8;
  assign rnd_v = s1_mv_q + 47'd8;
  assign den_sum = QOne + (64'(s9_k1r2_q) <<< 2) + 64'(s9_k2r4_q) * 64'sd6
                 + (64'(s9_p1y_q) <<< 3) + (64'(s9_p2x_q) <<< 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mu_q <= 47'(pix_i.pixel_u) * 47'(cfg_i.inv_scale_x);
      s1_mv_q <= 47'(pix_i.pixel_v) * 47'(cfg_i.inv_scale_y);

      s2_x_q <= sat32($signed({21'd0, rnd_u[46:4]}) + 64'(cfg_i.offset_x));
      s2_y_q <= sat32($signed({21'd0, rnd_v[46:4]}) + 64'(cfg_i.offset_y));

      s3_mxx_q <= 64'(s2_x_q) * 64'(s2_x_q);
      s3_myy_q <= 64'(s2_y_q) * 64'(s2_y_q);
      s3_mxy_q <= 64'(s2_x_q) * 64'(s2_y_q);
      s3_mp1y_q <= 64'(cfg_i.p_tangential_1) * 64'(s2_y_q);
      s3_mp2x_q <= 64'(cfg_i.p_tangential_2) * 64'(s2_x_q);
      s3_x_q <= s2_x_q;
      s3_y_q <= s2_y_q;

      s4_xx_q <= rnd_sat(s3_mxx_q);
      s4_yy_q <= rnd_sat(s3_myy_q);
      s4_xy_q <= rnd_sat(s3_mxy_q);
      s4_p1y_q <= rnd_sat(s3_mp1y_q);
      s4_p2x_q <= rnd_sat(s3_mp2x_q);
      s4_x_q <= s3_x_q;
      s4_y_q <= s3_y_q;

      s5_r2_q <= sat32(64'(s4_xx_q) + 64'(s4_yy_q));
      s5_xx_q <= s4_xx_q;
      s5_yy_q <= s4_yy_q;
      s5_xy_q <= s4_xy_q;
      s5_p1y_q <= s4_p1y_q;
      s5_p2x_q <= s4_p2x_q;
      s5_x_q <= s4_x_q;
      s5_y_q <= s4_y_q;

      s6_mr4_q <= 64'(s5_r2_q) * 64'(s5_r2_q);
      s6_mk1r2_q <= 64'(cfg_i.k_radial_1) * 64'(s5_r2_q);
      s6_mp1xy_q <= 64'(cfg_i.p_tangential_1) * 64'(s5_xy_q);
      s6_mp2xy_q <= 64'(cfg_i.p_tangential_2) * 64'(s5_xy_q);
      s6_sx_q <= sat32(64'(s5_r2_q) + (64'(s5_xx_q) <<< 1));
      s6_sy_q <= sat32(64'(s5_r2_q) + (64'(s5_yy_q) <<< 1));
      s6_p1y_q <= s5_p1y_q;
      s6_p2x_q <= s5_p2x_q;
      s6_x_q <= s5_x_q;
      s6_y_q <= s5_y_q;

      s7_r4_q <= rnd_sat(s6_mr4_q);
      s7_k1r2_q <= rnd_sat(s6_mk1r2_q);
      s7_p1xy_q <= rnd_sat(s6_mp1xy_q);
      s7_p2xy_q <= rnd_sat(s6_mp2xy_q);
      s7_mp2sx_q <= 64'(cfg_i.p_tangential_2) * 64'(s6_sx_q);
      s7_mp1sy_q <= 64'(cfg_i.p_tangential_1) * 64'(s6_sy_q);
      s7_p1y_q <= s6_p1y_q;
      s7_p2x_q <= s6_p2x_q;
      s7_x_q <= s6_x_q;
      s7_y_q <= s6_y_q;

      s8_mk2r4_q <= 64'(cfg_i.k_radial_2) * 64'(s7_r4_q);
      s8_k1r2_q <= s7_k1r2_q;
      s8_p1xy_q <= s7_p1xy_q;
      s8_p2xy_q <= s7_p2xy_q;
      s8_p2sx_q <= rnd_sat(s7_mp2sx_q);
      s8_p1sy_q <= rnd_sat(s7_mp1sy_q);
      s8_p1y_q <= s7_p1y_q;
      s8_p2x_q <= s7_p2x_q;
      s8_x_q <= s7_x_q;
      s8_y_q <= s7_y_q;

      s9_k2r4_q <= rnd_sat(s8_mk2r4_q);
      s9_k1r2_q <= s8_k1r2_q;
      s9_tx_q <= sat32((64'(s8_p1xy_q) <<< 1) + 64'(s8_p2sx_q));
      s9_ty_q <= sat32(64'(s8_p1sy_q) + (64'(s8_p2xy_q) <<< 1));
      s9_p1y_q <= s8_p1y_q;
      s9_p2x_q <= s8_p2x_q;
      s9_x_q <= s8_x_q;
      s9_y_q <= s8_y_q;

      s10_rad_q <= sat32(64'(s9_k1r2_q) + 64'(s9_k2r4_q));
      s10_den_q <= sat32(den_sum);
      s10_tx_q <= s9_tx_q;
      s10_ty_q <= s9_ty_q;
      s10_x_q <= s9_x_q;
      s10_y_q <= s9_y_q;

      s11_mrx_q <= 64'(s10_rad_q) * 64'(s10_x_q);
      s11_mry_q <= 64'(s10_rad_q) * 64'(s10_y_q);
      s11_den_q <= s10_den_q;
      s11_tx_q <= s10_tx_q;
      s11_ty_q <= s10_ty_q;
      s11_x_q <= s10_x_q;
      s11_y_q <= s10_y_q;

      s12_rx_q <= sat32(64'(rnd_sat(s11_mrx_q)) + 64'(s11_tx_q));
      s12_ry_q <= sat32(64'(rnd_sat(s11_mry_q)) + 64'(s11_ty_q));
      s12_den_q <= s11_den_q;
      s12_x_q <= s11_x_q;
      s12_y_q <= s11_y_q;
    end
  end

  assign vld_o = vld_q[Depth-1];
  assign x_o = s12_x_q;
  assign y_o = s12_y_q;
  assign res_x_o = s12_rx_q;
  assign res_y_o = s12_ry_q;
  assign den_o = s12_den_q;

endmodule
`default_nettype wire

/* sv/lpu_div.sv */
// pipelined restoring divider, one quotient bit per stage, saturated signed quotient
`default_nettype none
module lpu_div
  import lpu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [31:0] num_i,   // residual, scaled by 2^28 inside
  input  wire logic [30:0]        den_i,   // positive divisor
  input  wire side_t              side_i,
  output logic signed [31:0]      quo_o,
  output side_t                   side_o
);

  localparam int Steps = 32;

  logic [31:0] mag;
  logic        ovf;

  logic [Steps:0]       vld_q;
  side_t                side_q [Steps+1];
  logic [30:0]          rem_q  [Steps+1];
  logic [31:0]          lo_q   [Steps+1];
  logic [31:0]          quo_q  [Steps+1];
  logic [30:0]          den_q  [Steps+1];
  logic                 neg_q  [Steps+1];
  logic                 ovf_q  [Steps+1];

  assign mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  // quotient of at least 2^32 when the high dividend bits reach the divisor
  assign ovf = {3'd0, mag[31:4]} >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], side_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      rem_q[0] <= {3'd0, mag[31:4]};
      lo_q[0] <= {mag[3:0], 28'd0};
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= num_i[31];
      ovf_q[0] <= ovf;
      for (int s = 0; s < Steps; s++) begin
        logic [31:0] trial;
        logic        take;
        trial = {rem_q[s], lo_q[s][31]};
        take = trial >= {1'b0, den_q[s]};
        rem_q[s+1] <= take ? 31'(trial - {1'b0, den_q[s]}) : trial[30:0];
        lo_q[s+1] <= {lo_q[s][30:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][30:0], take};
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  always_comb begin
    side_o = side_q[Steps];
    side_o.vld = vld_q[Steps];
    if (ovf_q[Steps] || quo_q[Steps][31]) begin
      quo_o = neg_q[Steps] ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg_q[Steps]) begin
      quo_o = -$signed(quo_q[Steps]);
    end else begin
      quo_o = $signed(quo_q[Steps]);
    end
  end

endmodule
`default_nettype wire

/* sv/lens_point_undistort.sv */
// top level: register file, undistortion pipeline, dividers and output register
//
//  channel | signals                               | transaction when
//  --------+---------------------------------------+-------------------------------
//  input   | in_valid_i, in_ready_o, in_data_i     | in_valid_i & in_ready_o
//  output  | out_valid_o, out_ready_i, out_data_o  | out_valid_o & out_ready_i
//  config  | psel, penable, pwrite, paddr, pwdata  | psel & penable & pwrite & pready
//
// one keypoint per cycle unless the output stalls; 12 arithmetic stages, 33
// divider stages (a quotient bit per stage after the first), output register
// reset clears all valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
`default_nettype none
module lens_point_undistort
  import lpu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pix_t                in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output res_t                     out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [RegAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic en;

  logic fr_vld;
  logic signed [31:0] fr_x, fr_y, fr_rx, fr_ry, fr_den;
  logic fr_bad;
  logic [30:0] div_den;
  side_t sx_in, sy_in, sx_out, sy_out;
  logic signed [31:0] qx, qy;

  logic out_valid_q;
  res_t out_q;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_radial_1 <= '0;
      cfg_q.k_radial_2 <= '0;
      cfg_q.p_tangential_1 <= '0;
      cfg_q.p_tangential_2 <= '0;
      cfg_q.inv_scale_x <= 31'(QOne);
      cfg_q.inv_scale_y <= 31'(QOne);
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_K_RADIAL_1: cfg_q.k_radial_1 <= pwdata;
        REG_K_RADIAL_2: cfg_q.k_radial_2 <= pwdata;
        REG_P_TANGENTIAL_1: cfg_q.p_tangential_1 <= pwdata;
        REG_P_TANGENTIAL_2: cfg_q.p_tangential_2 <= pwdata;
        REG_INV_SCALE_X: cfg_q.inv_scale_x <= pwdata[30:0];
        REG_INV_SCALE_Y: cfg_q.inv_scale_y <= pwdata[30:0];
        REG_OFFSET_X: cfg_q.offset_x <= pwdata;
        default: cfg_q.offset_y <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_K_RADIAL_1: prdata = cfg_q.k_radial_1;
      REG_K_RADIAL_2: prdata = cfg_q.k_radial_2;
      REG_P_TANGENTIAL_1: prdata = cfg_q.p_tangential_1;
      REG_P_TANGENTIAL_2: prdata = cfg_q.p_tangential_2;
      REG_INV_SCALE_X: prdata = {1'b0, cfg_q.inv_scale_x};
      REG_INV_SCALE_Y: prdata = {1'b0, cfg_q.inv_scale_y};
      REG_OFFSET_X: prdata = cfg_q.offset_x;
      default: prdata = cfg_q.offset_y;
    endcase
  end

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  lpu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .pix_i   (in_data_i),
    .cfg_i   (cfg_q),
    .vld_o   (fr_vld),
    .x_o     (fr_x),
    .y_o     (fr_y),
    .res_x_o (fr_rx),
    .res_y_o (fr_ry),
    .den_o   (fr_den)
  );

  // a bad denominator still runs through the divider, with a harmless divisor
  assign fr_bad = (fr_den <= 32'sd0);
  assign div_den = fr_bad ? 31'd1 : fr_den[30:0];
  assign sx_in = '{vld: fr_vld, bad: fr_bad, coord: fr_x};
  assign sy_in = '{vld: fr_vld, bad: fr_bad, coord: fr_y};

  lpu_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (fr_rx),
    .den_i  (div_den),
    .side_i (sx_in),
    .quo_o  (qx),
    .side_o (sx_out)
  );

  lpu_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (fr_ry),
    .den_i  (div_den),
    .side_i (sy_in),
    .quo_o  (qy),
    .side_o (sy_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sx_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.denom_bad <= sx_out.bad;
      if (sx_out.bad) begin
        out_q.norm_x <= sx_out.coord;
        out_q.norm_y <= sy_out.coord;
      end else begin
        out_q.norm_x <= sat32(64'(sx_out.coord) - 64'(qx));
        out_q.norm_y <= sat32(64'(sy_out.coord) - 64'(qy));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // both divider lanes carry the same transactions in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sx_out.vld == sy_out.vld) && (!sx_out.vld || (sx_out.bad == sy_out.bad)))
    else $error("divider lanes out of step");

  // a result appears only when the divider delivered one the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sx_out.vld))
    else $error("result without a transaction from the divider");

  // the output register holds while the consumer stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_q)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

/* bench/lpu_checker.sv */
// checker for the lens point undistort block: predicts each keypoint result and compares
`timescale 1ns / 100ps
module lpu_checker
  import lpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  pix_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_t        out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          bad_den_cnt_o
);

  typedef logic signed [63:0] s64_t;

  cfg_t cfg;
  res_t undist_q[$];

  function automatic s64_t clip(input s64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift is floor, so adding half gives round half up
  function automatic s64_t rshift(input s64_t v, input int s);
    s64_t t;
    t = v + (s64_t'(1) <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic s64_t fmul(input s64_t a, input s64_t b);
    return clip(rshift(a * b, 28));
  endfunction

  function automatic res_t undistort(input pix_t p);
    s64_t x, y, xx, yy, xy, r2, r4, k1r2, k2r4, rad, tx, ty, rx, ry, den, qx, qy;
    s64_t k1, k2, p1, p2, one, ox, oy;
    res_t r;
    one = 64'sd268435456;
    k1 = s64_t'(cfg.k_radial_1);
    k2 = s64_t'(cfg.k_radial_2);
    p1 = s64_t'(cfg.p_tangential_1);
    p2 = s64_t'(cfg.p_tangential_2);
    x = clip(rshift(s64_t'({1'b0, p.pixel_u}) * s64_t'({1'b0, cfg.inv_scale_x}), 4)
             + s64_t'(cfg.offset_x));
    y = clip(rshift(s64_t'({1'b0, p.pixel_v}) * s64_t'({1'b0, cfg.inv_scale_y}), 4)
             + s64_t'(cfg.offset_y));
    xx = fmul(x, x);
    yy = fmul(y, y);
    xy = fmul(x, y);
    r2 = clip(xx + yy);
    r4 = fmul(r2, r2);
    k1r2 = fmul(k1, r2);
    k2r4 = fmul(k2, r4);
    rad = clip(k1r2 + k2r4);
    tx = clip(2 * fmul(p1, xy) + fmul(p2, clip(r2 + 2 * xx)));
    ty = clip(fmul(p1, clip(r2 + 2 * yy)) + 2 * fmul(p2, xy));
    rx = clip(fmul(rad, x) + tx);
    ry = clip(fmul(rad, y) + ty);
    den = clip(one + 4 * k1r2 + 6 * k2r4 + 8 * fmul(p1, y) + 8 * fmul(p2, x));
    if (den <= 0) begin
      r.norm_x = x[31:0];
      r.norm_y = y[31:0];
      r.denom_bad = 1'b1;
    end else begin
      qx = clip((rx * one) / den);
      qy = clip((ry * one) / den);
      ox = clip(x - qx);
      oy = clip(y - qy);
      r.norm_x = ox[31:0];
      r.norm_y = oy[31:0];
      r.denom_bad = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cfg <= '{0, 0, 0, 0, 31'h10000000, 31'h10000000, 0, 0};
      fail_cnt_o <= 0;
      bad_den_cnt_o <= 0;
      pending_o <= 0;
      undist_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i[4:2])
          REG_K_RADIAL_1:     cfg.k_radial_1 <= pwdata_i;
          REG_K_RADIAL_2:     cfg.k_radial_2 <= pwdata_i;
          REG_P_TANGENTIAL_1: cfg.p_tangential_1 <= pwdata_i;
          REG_P_TANGENTIAL_2: cfg.p_tangential_2 <= pwdata_i;
          REG_INV_SCALE_X:    cfg.inv_scale_x <= pwdata_i[30:0];
          REG_INV_SCALE_Y:    cfg.inv_scale_y <= pwdata_i[30:0];
          REG_OFFSET_X:       cfg.offset_x <= pwdata_i;
          REG_OFFSET_Y:       cfg.offset_y <= pwdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) undist_q.insert(undist_q.size(), undistort(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (undist_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result %h", out_data_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = undist_q.pop_front();
          if (want.denom_bad) bad_den_cnt_o <= bad_den_cnt_o + 1;
          if (want !== out_data_i) begin
            if (fail_cnt_o < 10)
              $display("mismatch: x exp %h got %h, y exp %h got %h, bad exp %b got %b",
                       want.norm_x, out_data_i.norm_x, want.norm_y, out_data_i.norm_y,
                       want.denom_bad, out_data_i.denom_bad);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_o <= undist_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// testbench top: stimulus, register setup and verdict for the lens point undistort block
`timescale 1ns / 100ps
module tb_top
  import lpu_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  pix_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  res_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt, pending, bad_den_cnt;
  int          cycles = 0;
  int          sent = 0;

  always #1 clk_i = ~clk_i;

  lens_point_undistort i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lpu_checker i_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_cnt_o(fail_cnt), .pending_o(pending),
    .bad_den_cnt_o(bad_den_cnt)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver may drop ready after each accepted result, with calm stretches
  always @(posedge clk_i) begin
    int hold;
    if (rst_ni) begin
      if (out_ready_i && out_valid_o) begin
        hold = (sent % 400 < 80) ? 0 : $urandom_range(0, 15);
        if (hold != 0) out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic reg_wr(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after a transaction so the next one can follow without a gap
  task automatic send_pixel(input logic [15:0] u, input logic [15:0] v, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{u, v};
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // mild lens in mode 0 (small coefficients, scale, offsets), else edge or random values
  task automatic set_lens(input int mode);
    logic [31:0] v;
    if (mode == 0) begin
      reg_wr(REG_K_RADIAL_1, $urandom_range(0, 32'h06000000) - 32'h03000000);
      reg_wr(REG_K_RADIAL_2, $urandom_range(0, 32'h02000000) - 32'h01000000);
      reg_wr(REG_P_TANGENTIAL_1, $urandom_range(0, 32'h00400000) - 32'h00200000);
      reg_wr(REG_P_TANGENTIAL_2, $urandom_range(0, 32'h00400000) - 32'h00200000);
      v = $urandom_range(10000, 60000);
      reg_wr(REG_INV_SCALE_X, v);
      reg_wr(REG_INV_SCALE_Y, v + $urandom_range(0, 2000));
      reg_wr(REG_OFFSET_X, -($urandom_range(100000, 600000) * 32'd16));
      reg_wr(REG_OFFSET_Y, -($urandom_range(100000, 600000) * 32'd16));
    end else begin
      for (int r = 0; r < 8; r++) begin
        case ($urandom_range(0, 3))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'h0;
          default: v = $urandom;
        endcase
        reg_wr(r[2:0], v);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset defaults: identity mapping, extremes of both coordinates
    send_pixel(16'h0000, 16'h0000, 0);
    send_pixel(16'hffff, 16'hffff, 0);
    send_pixel(16'hffff, 16'h0000, 0);
    send_pixel(16'h5555, 16'haaaa, 0);
    drain();
    // negative denominator through a large negative k1
    reg_wr(REG_K_RADIAL_1, 32'h80000000);
    reg_wr(REG_INV_SCALE_X, 32'h7fffffff);
    reg_wr(REG_INV_SCALE_Y, 32'h00010000);
    reg_wr(REG_OFFSET_X, 32'h80000000);
    reg_wr(REG_OFFSET_Y, 32'h7fffffff);
    send_pixel(16'h0010, 16'h0010, 0);
    send_pixel(16'hffff, 16'h0000, 0);
    send_pixel(16'h0000, 16'hffff, 0);
    drain();
    reg_wr(REG_K_RADIAL_2, 32'h7fffffff);
    reg_wr(REG_P_TANGENTIAL_1, 32'h80000000);
    reg_wr(REG_P_TANGENTIAL_2, 32'h7fffffff);
    reg_wr(REG_OFFSET_X, 32'h0);
    reg_wr(REG_OFFSET_Y, 32'h0);
    reg_wr(REG_INV_SCALE_X, 32'h0);
    send_pixel(16'h0001, 16'hffff, 0);
    send_pixel(16'h8000, 16'h0001, 0);
    drain();
    set_lens(0);
    for (int i = 0; i < 10; i++) send_pixel($urandom, $urandom, 0);
    drain();
    for (int ph = 0; ph < 13; ph++) begin
      set_lens((ph % 4 == 3) ? 1 : 0);
      for (int i = 0; i < 150; i++)
        send_pixel($urandom, $urandom, (ph % 3) != 1);
      drain();
    end
    $display("sent %0d keypoints over 17 lens settings, %0d with a bad denominator",
             sent, bad_den_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
